### sv/pwfs_pkg.sv
// shared types and constants for the pulse-width frame sender
package pwfs_pkg;

  // frame and timing defaults
  localparam int unsigned FRAME_BITS_DEFAULT = 16;
  localparam int unsigned FRAME_BITS_MAX     = 32;
  localparam int unsigned WORD_W             = 16;
  localparam int unsigned TICK_W             = 16;
  localparam logic [TICK_W-1:0] TICKS_RESET  = 16'd833;

  // unit counts per segment of the frame
  localparam int unsigned UNIT_W = 3;
  localparam logic [UNIT_W-1:0] UNITS_START = 3'd2;
  localparam logic [UNIT_W-1:0] UNITS_LONG  = 3'd4;
  localparam logic [UNIT_W-1:0] UNITS_SHORT = 3'd1;
  localparam logic [UNIT_W-1:0] UNITS_STOP  = 3'd1;

  // command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SEND = 1'b1;

  // frame phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_BHIGH = 3'd2,
    PH_BLOW  = 3'd3,
    PH_STOP  = 3'd4
  } phase_t;

  // input beat
  typedef struct packed {
    logic       command;
    logic [3:0] mode;
    logic [3:0] red;
    logic [3:0] green;
    logic [3:0] blue;
  } req_t;

  // result beat
  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic rejected;
  } rsp_t;

endpackage

### sv/pwfs_core.sv
// frame sequencer: phase, unit and tick counters, shift register, line level
module pwfs_core import pwfs_pkg::*; #(
  parameter int unsigned FRAME_BITS = FRAME_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  req_t              req,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata,
  output rsp_t              rsp
);

  localparam int unsigned BITS_W = $clog2(FRAME_BITS + 1);
  localparam logic [BITS_W-1:0] BITS_FULL = BITS_W'(FRAME_BITS);

  logic [TICK_W-1:0]     ticks_per_unit;
  logic [FRAME_BITS-1:0] frame_shift, frame_shift_next;
  logic [BITS_W-1:0]     bits_left, bits_left_next;
  phase_t                phase, phase_next;
  logic [UNIT_W-1:0]     units_left, units_left_next;
  logic [TICK_W-1:0]     tick_count, tick_count_next;
  logic                  line_reg, line_reg_next;
  logic                  done, rej;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_unit <= TICKS_RESET;
    end else if (cfg_we) begin
      ticks_per_unit <= cfg_wdata;
    end
  end

  // state registers, updated once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_shift <= '0;
      bits_left   <= '0;
      phase       <= PH_IDLE;
      units_left  <= '0;
      tick_count  <= '0;
      line_reg    <= 1'b1;
    end else if (accept) begin
      frame_shift <= frame_shift_next;
      bits_left   <= bits_left_next;
      phase       <= phase_next;
      units_left  <= units_left_next;
      tick_count  <= tick_count_next;
      line_reg    <= line_reg_next;
    end
  end

  // next state for one beat
  always_comb begin
    logic [TICK_W-1:0]     limit;
    logic [TICK_W:0]       tick_sum;
    logic [UNIT_W-1:0]     units_dec;
    logic [FRAME_BITS-1:0] shifted;
    logic [BITS_W-1:0]     bits_dec;
    logic [31:0]           word_ext;

    frame_shift_next = frame_shift;
    bits_left_next   = bits_left;
    phase_next       = phase;
    units_left_next  = units_left;
    tick_count_next  = tick_count;
    line_reg_next    = line_reg;
    done             = 1'b0;
    rej              = 1'b0;

    limit     = (ticks_per_unit == '0) ? TICK_W'(1) : ticks_per_unit;
    tick_sum  = {1'b0, tick_count} + (TICK_W+1)'(1);
    units_dec = (units_left != '0) ? units_left - UNIT_W'(1) : '0;
    shifted   = frame_shift << 1;
    bits_dec  = (bits_left != '0) ? bits_left - BITS_W'(1) : '0;
    word_ext  = {16'b0, req.mode, req.red, req.green, req.blue};

    if (req.command == CMD_SEND) begin
      if (phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        frame_shift_next = word_ext[FRAME_BITS-1:0];
        bits_left_next   = BITS_FULL;
        phase_next       = PH_START;
        units_left_next  = UNITS_START;
        tick_count_next  = '0;
        line_reg_next    = 1'b0;
      end
    end else if (phase != PH_IDLE) begin
      tick_count_next = tick_sum[TICK_W-1:0];
      if (tick_sum >= {1'b0, limit}) begin
        tick_count_next = '0;
        units_left_next = units_dec;
        if (units_dec == '0) begin
          unique case (phase)
            PH_START: begin
              phase_next      = PH_BHIGH;
              units_left_next = frame_shift[FRAME_BITS-1] ? UNITS_LONG : UNITS_SHORT;
              line_reg_next   = 1'b1;
            end
            PH_BHIGH: begin
              phase_next      = PH_BLOW;
              units_left_next = frame_shift[FRAME_BITS-1] ? UNITS_SHORT : UNITS_LONG;
              line_reg_next   = 1'b0;
            end
            PH_BLOW: begin
              frame_shift_next = shifted;
              bits_left_next   = bits_dec;
              if (bits_dec == '0) begin
                phase_next      = PH_STOP;
                units_left_next = UNITS_STOP;
              end else begin
                phase_next      = PH_BHIGH;
                units_left_next = shifted[FRAME_BITS-1] ? UNITS_LONG : UNITS_SHORT;
              end
              line_reg_next = 1'b1;
            end
            default: begin
              phase_next      = PH_IDLE;
              units_left_next = '0;
              line_reg_next   = 1'b1;
              done            = 1'b1;
            end
          endcase
        end
      end
    end
  end

  // result reflects the state after this beat
  always_comb begin
    rsp.line_level = line_reg_next;
    rsp.busy_res   = (phase_next != PH_IDLE);
    rsp.frame_done = done;
    rsp.rejected   = rej;
  end

endmodule

### sv/pulse_width_frame_sender_unit.sv
// top level: frame sequencer with a two-entry result buffer
// results are registered into the two-entry buffer and held there while rsp_ready stalls
// throughput: one beat per cycle; the two-entry result buffer keeps intake
//   open while one result waits, req_ready drops only when both entries hold
// reset: synchronous active-high rst empties the buffer, idles the line high
//   and sets ticks_per_unit to 833
module pulse_width_frame_sender_unit import pwfs_pkg::*; #(
  parameter int unsigned FRAME_BITS = FRAME_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  req_t              req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rsp_t              rsp,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata
);

  logic accept, pop;
  rsp_t rsp_new;
  rsp_t skid;
  logic skid_valid;

  assign req_ready = !skid_valid;
  assign accept    = req_valid && req_ready;
  assign pop       = rsp_valid && rsp_ready;

  pwfs_core #(
    .FRAME_BITS(FRAME_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .req      (req),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .rsp      (rsp_new)
  );

  // result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= accept;
      end else begin
        rsp_valid <= accept;
      end
    end else if (accept) begin
      if (rsp_valid) begin
        skid_valid <= 1'b1;
      end else begin
        rsp_valid <= 1'b1;
      end
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        rsp <= skid;
        if (accept) begin
          skid <= rsp_new;
        end
      end else if (accept) begin
        rsp <= rsp_new;
      end
    end else if (accept) begin
      if (rsp_valid) begin
        skid <= rsp_new;
      end else begin
        rsp <= rsp_new;
      end
    end
  end

endmodule

### sv/pwfs_checker.sv
// port-level checks for the pulse-width frame sender, bound to the top level
module pwfs_checker import pwfs_pkg::*; (
  input logic clk,
  input logic rst,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // frame end leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.frame_done |-> !rsp.busy_res && rsp.line_level)
    else $error("frame done while still busy or line low");

  // a rejected send only happens while busy
  a_rej_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.rejected |-> rsp.busy_res && !rsp.frame_done)
    else $error("send rejected while idle");

  // idle line stays high
  a_idle_high: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.busy_res |-> rsp.line_level)
    else $error("line low while idle");

endmodule

bind pulse_width_frame_sender_unit pwfs_checker u_pwfs_checker (
  .clk      (clk),
  .rst      (rst),
  .rsp_valid(rsp_valid),
  .rsp_ready(rsp_ready),
  .rsp      (rsp)
);
